// File: sv/sdld_pkg.sv
`default_nettype none

package sdld_pkg;

  // Display geometry
  localparam int unsigned NumSectionsDefault = 2;
  localparam int unsigned ColumnsPerSection  = 16;
  localparam int unsigned ColumnW            = 4;

  // Request kinds
  localparam logic ReqColumnLatch = 1'b0;
  localparam logic ReqSegmentWrite = 1'b1;

  // Half selects
  localparam logic HalfUpper = 1'b0;
  localparam logic HalfLower = 1'b1;

  localparam logic [6:0] AsciiDash = 7'h2D;

  typedef logic [15:0] seg_word_t;
  typedef logic [6:0]  ascii_t;

  // Map a sixteen-segment pattern to the character it shows
  function automatic ascii_t decode_glyph(input seg_word_t word);
    ascii_t ch;
    unique case (word)
      16'h0000: ch = 7'h20;  // blank
      16'h3F00: ch = 7'h30;
      16'h0600: ch = 7'h31;
      16'h5B08: ch = 7'h32;
      16'h4F08: ch = 7'h33;
      16'h6608: ch = 7'h34;
      16'h6D08: ch = 7'h35;
      16'h7D08: ch = 7'h36;
      16'h0700: ch = 7'h37;
      16'h7F08: ch = 7'h38;
      16'h6F08: ch = 7'h39;
      16'h7708: ch = 7'h41;
      16'h0F2A: ch = 7'h42;
      16'h3900: ch = 7'h43;
      16'h0F22: ch = 7'h44;
      16'h7908: ch = 7'h45;
      16'h7108: ch = 7'h46;
      16'h3D08: ch = 7'h47;
      16'h7608: ch = 7'h48;
      16'h0922: ch = 7'h49;
      16'h1E00: ch = 7'h4A;
      16'h7014: ch = 7'h4B;
      16'h3800: ch = 7'h4C;
      16'h3605: ch = 7'h4D;
      16'h3611: ch = 7'h4E;
      16'h7308: ch = 7'h50;
      16'h3F10: ch = 7'h51;
      16'h7318: ch = 7'h52;
      16'h0122: ch = 7'h54;
      16'h3E00: ch = 7'h55;
      16'h3044: ch = 7'h56;
      16'h3E20: ch = 7'h57;
      16'h0055: ch = 7'h58;
      16'h0025: ch = 7'h59;
      16'h0944: ch = 7'h5A;
      default:  ch = AsciiDash;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: sv/segment_display_latch_decoder_top.sv
`default_nettype none

// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_ready_o  req_type, column_select, section,
//                                              half_select, data_byte
// out      output     out_valid_o / out_ready_i out_column, out_section, char_code
//
// One transfer per cycle in while in_ready_o is high, one result at most per write.
// From input transfer to result an item passes the registered segment store read,
// then merge, decode and the result register.
// Reset clears the latched column and marks every store entry blank at once
// through per-entry valid bits; no clearing pass.
// A waiting result stalls the merge stage; input is still taken while the merge
// stage is empty or moving.
module segment_display_latch_decoder_top #(
  parameter int unsigned NUM_SECTIONS = sdld_pkg::NumSectionsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic                         req_type_i,
  input  wire logic [sdld_pkg::ColumnW-1:0] column_select_i,
  input  wire logic                         section_i,
  input  wire logic                         half_select_i,
  input  wire logic [7:0]                   data_byte_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [sdld_pkg::ColumnW-1:0] out_column_o,
  output      logic                         out_section_o,
  output      logic [6:0]                   char_code_o
);

  localparam int unsigned Depth = NUM_SECTIONS * sdld_pkg::ColumnsPerSection;
  localparam int unsigned AddrW = $clog2(Depth);

  // Segment store and its blank marks
  sdld_pkg::seg_word_t mem [Depth];
  logic [Depth-1:0]    written_q;

  logic [sdld_pkg::ColumnW-1:0] column_q;

  // Merge stage
  logic                         s1_valid_q;
  logic [AddrW-1:0]             s1_addr_q;
  logic [sdld_pkg::ColumnW-1:0] s1_column_q;
  logic                         s1_section_q;
  logic                         s1_half_q;
  logic [7:0]                   s1_byte_q;
  sdld_pkg::seg_word_t          rd_data_q;
  logic                         rd_written_q;
  logic                         fwd_hit_q;
  sdld_pkg::seg_word_t          fwd_data_q;

  // Result register
  logic                         out_valid_q;
  logic [sdld_pkg::ColumnW-1:0] out_column_q;
  logic                         out_section_q;
  sdld_pkg::ascii_t             out_char_q;

  logic                in_xfer;
  logic                is_write;
  logic                sec_ok;
  logic [AddrW-1:0]    rd_addr;
  logic                s1_adv;
  sdld_pkg::seg_word_t old_word;
  sdld_pkg::seg_word_t new_word;
  logic                changed;
  logic                do_write;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_write   = (req_type_i == sdld_pkg::ReqSegmentWrite);
  assign sec_ok     = (32'(section_i) < NUM_SECTIONS);
  assign rd_addr    = AddrW'(32'(section_i) * sdld_pkg::ColumnsPerSection + 32'(column_q));

  // Pick the current word: last write to the same entry, the store, or blank if never written
  always_comb begin
    if (fwd_hit_q) begin
      old_word = fwd_data_q;
    end else if (rd_written_q) begin
      old_word = rd_data_q;
    end else begin
      old_word = '0;
    end
    // Merge the byte, drop period and comma of the old word
    if (s1_half_q == sdld_pkg::HalfUpper) begin
      new_word = {s1_byte_q, 1'b0, old_word[6:0]};
    end else begin
      new_word = {1'b0, old_word[14:8], s1_byte_q};
    end
  end

  assign changed  = (new_word != old_word);
  assign do_write = s1_valid_q && s1_adv && changed;

  // Latch column select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
    end else if (in_xfer && !is_write) begin
      column_q <= column_select_i;
    end
  end

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[s1_addr_q] <= new_word;
    end
    if (in_xfer) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (do_write) begin
      written_q[s1_addr_q] <= 1'b1;
    end
  end

  // Advance the merge stage; forward only to a write that enters it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_xfer && is_write && sec_ok;
      fwd_hit_q  <= in_xfer && is_write && sec_ok && do_write && (s1_addr_q == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_addr_q    <= rd_addr;
      s1_column_q  <= column_q;
      s1_section_q <= section_i;
      s1_half_q    <= half_select_i;
      s1_byte_q    <= data_byte_i;
      rd_written_q <= written_q[rd_addr];
      fwd_data_q   <= new_word;
    end
  end

  // Hold or load the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q && changed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      out_column_q  <= s1_column_q;
      out_section_q <= s1_section_q;
      out_char_q    <= sdld_pkg::decode_glyph(new_word);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_column_o  = out_column_q;
  assign out_section_o = out_section_q;
  assign char_code_o   = out_char_q;

  // Checks
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_char_q >= 7'h20) && (out_char_q <= 7'h5A))
    else $error("result character out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a waiting result");

  a_fwd_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s1_valid_q)
    else $error("forward hit with empty merge stage");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result without a merged write");

endmodule

`default_nettype wire

// File: dv/display_char_checker.sv
`timescale 1ns / 100ps

// Sixteen-segment glyph table shared by the checker and the stimulus
package seg_glyph_pkg;

  localparam int unsigned NumGlyphs = 35;

  // Return {ascii, pattern} for one table row
  function automatic logic [22:0] glyph_entry(input int unsigned idx);
    logic [22:0] row;
    case (idx)
      0:       row = {7'h20, 16'h0000};
      1:       row = {7'h30, 16'h3F00};
      2:       row = {7'h31, 16'h0600};
      3:       row = {7'h32, 16'h5B08};
      4:       row = {7'h33, 16'h4F08};
      5:       row = {7'h34, 16'h6608};
      6:       row = {7'h35, 16'h6D08};
      7:       row = {7'h36, 16'h7D08};
      8:       row = {7'h37, 16'h0700};
      9:       row = {7'h38, 16'h7F08};
      10:      row = {7'h39, 16'h6F08};
      11:      row = {7'h41, 16'h7708};
      12:      row = {7'h42, 16'h0F2A};
      13:      row = {7'h43, 16'h3900};
      14:      row = {7'h44, 16'h0F22};
      15:      row = {7'h45, 16'h7908};
      16:      row = {7'h46, 16'h7108};
      17:      row = {7'h47, 16'h3D08};
      18:      row = {7'h48, 16'h7608};
      19:      row = {7'h49, 16'h0922};
      20:      row = {7'h4A, 16'h1E00};
      21:      row = {7'h4B, 16'h7014};
      22:      row = {7'h4C, 16'h3800};
      23:      row = {7'h4D, 16'h3605};
      24:      row = {7'h4E, 16'h3611};
      25:      row = {7'h50, 16'h7308};
      26:      row = {7'h51, 16'h3F10};
      27:      row = {7'h52, 16'h7318};
      28:      row = {7'h54, 16'h0122};
      29:      row = {7'h55, 16'h3E00};
      30:      row = {7'h56, 16'h3044};
      31:      row = {7'h57, 16'h3E20};
      32:      row = {7'h58, 16'h0055};
      33:      row = {7'h59, 16'h0025};
      default: row = {7'h5A, 16'h0944};
    endcase
    return row;
  endfunction

endpackage

module display_char_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire logic       req_type_i,
  input  wire logic [3:0] column_select_i,
  input  wire logic       section_i,
  input  wire logic       half_select_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic [3:0] out_column_i,
  input  wire logic       out_section_i,
  input  wire logic [6:0] char_code_i,
  output int              fail_count_o,
  output int              pending_o
);

  localparam int unsigned StoreDepth =
    sdld_pkg::NumSectionsDefault * sdld_pkg::ColumnsPerSection;
  localparam logic [15:0] DotBits = 16'h8080;

  typedef struct packed {
    logic [3:0] column;
    logic       section;
    logic [6:0] ch;
  } char_update_t;

  logic [3:0]          latched_col;
  sdld_pkg::seg_word_t seg_words [StoreDepth];
  char_update_t        char_updates_q [$];

  // Look a segment word up in the glyph table; unknown shapes show a dash
  function automatic sdld_pkg::ascii_t glyph_char(input sdld_pkg::seg_word_t word);
    logic [22:0] row;
    for (int unsigned i = 0; i < seg_glyph_pkg::NumGlyphs; i++) begin
      row = seg_glyph_pkg::glyph_entry(i);
      if (row[15:0] == word) return row[22:16];
    end
    return sdld_pkg::AsciiDash;
  endfunction

  // Track the display image, queue each changed character, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned         slot;
    sdld_pkg::seg_word_t old_word;
    sdld_pkg::seg_word_t new_word;
    logic [15:0]         repl_mask;
    logic [15:0]         placed;
    char_update_t        want;

    if (!rst_ni) begin
      latched_col = '0;
      for (int unsigned i = 0; i < StoreDepth; i++) seg_words[i] = '0;
      char_updates_q.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      // Check a result transfer against the oldest expected update
      if (out_valid_i && out_ready_i) begin
        if (char_updates_q.size() == 0) begin
          $error("unexpected result: column %0d section %0d char %h",
                 out_column_i, out_section_i, char_code_i);
          fail_count_o++;
        end else begin
          want = char_updates_q.pop_front();
          if (out_column_i !== want.column) begin
            $error("out_column: expected %0d, got %0d", want.column, out_column_i);
            fail_count_o++;
          end
          if (out_section_i !== want.section) begin
            $error("out_section: expected %0d, got %0d", want.section, out_section_i);
            fail_count_o++;
          end
          if (char_code_i !== want.ch) begin
            $error("char_code: expected %h, got %h", want.ch, char_code_i);
            fail_count_o++;
          end
        end
      end

      // Apply an input transfer to the display image
      if (in_valid_i && in_ready_i) begin
        if (req_type_i == sdld_pkg::ReqColumnLatch) begin
          latched_col = column_select_i;
        end else if (section_i < sdld_pkg::NumSectionsDefault) begin
          slot     = section_i * sdld_pkg::ColumnsPerSection + latched_col;
          old_word = seg_words[slot];
          if (half_select_i == sdld_pkg::HalfUpper) begin
            repl_mask = 16'hFF00;
            placed    = {data_byte_i, 8'h00};
          end else begin
            repl_mask = 16'h00FF;
            placed    = {8'h00, data_byte_i};
          end
          // Drop period and comma of the old word, then merge the new byte
          new_word = (old_word & ~(repl_mask | DotBits)) | placed;
          if (new_word != old_word) begin
            seg_words[slot] = new_word;
            want.column  = latched_col;
            want.section = section_i;
            want.ch      = glyph_char(new_word);
            char_updates_q.push_back(want);
          end
        end
      end
      pending_o = char_updates_q.size();
    end
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned RandomItems = 2000;
  localparam int unsigned MaxGap      = 4;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       req_type_i;
  logic [3:0] column_select_i;
  logic       section_i;
  logic       half_select_i;
  logic [7:0] data_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [3:0] out_column_o;
  logic       out_section_o;
  logic [6:0] char_code_o;
  int         fail_count;
  int         pending_updates;

  int unsigned accesses_sent = 0;
  bit          in_steady     = 1'b0;
  bit          out_steady    = 1'b0;

  segment_display_latch_decoder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .column_select_i (column_select_i),
    .section_i       (section_i),
    .half_select_i   (half_select_i),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_column_o    (out_column_o),
    .out_section_o   (out_section_o),
    .char_code_o     (char_code_o)
  );

  display_char_checker chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .req_type_i      (req_type_i),
    .column_select_i (column_select_i),
    .section_i       (section_i),
    .half_select_i   (half_select_i),
    .data_byte_i     (data_byte_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_column_i    (out_column_o),
    .out_section_i   (out_section_o),
    .char_code_i     (char_code_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_updates)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop for a hung run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Present one access after a random gap and hold it until the transfer
  task automatic issue_access(input logic kind, input logic [3:0] col, input logic sec,
                              input logic half, input logic [7:0] seg_byte);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= kind;
    column_select_i <= col;
    section_i       <= sec;
    half_select_i   <= half;
    data_byte_i     <= seg_byte;
    do @(posedge clk_i); while (!in_ready_o);
    accesses_sent++;
  endtask

  // Segment write with the don't-care column field randomized
  task automatic write_half(input logic sec, input logic half, input logic [7:0] seg_byte);
    issue_access(sdld_pkg::ReqSegmentWrite, 4'($urandom), sec, half, seg_byte);
  endtask

  // Column latch with the unused fields randomized
  task automatic latch_col(input logic [3:0] col);
    issue_access(sdld_pkg::ReqColumnLatch, col, 1'($urandom), 1'($urandom), 8'($urandom));
  endtask

  // Stall the result side at random, with occasional stretches of no stall
  initial begin
    int unsigned stall;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) out_steady = !out_steady;
      stall = out_steady ? 0 : $urandom_range(0, MaxGap);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Stimulus and verdict
  initial begin
    logic [22:0] glyph;
    logic [15:0] pattern;
    logic        sec;
    int unsigned pick;

    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    req_type_i      <= 1'b0;
    column_select_i <= '0;
    section_i       <= 1'b0;
    half_select_i   <= 1'b0;
    data_byte_i     <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: blank write at reset column, extremes, period and comma, repeats
    write_half(1'b0, sdld_pkg::HalfUpper, 8'h00);
    write_half(1'b0, sdld_pkg::HalfLower, 8'h55);
    latch_col(4'hF);
    write_half(1'b1, sdld_pkg::HalfUpper, 8'hFF);
    write_half(1'b1, sdld_pkg::HalfLower, 8'hFF);
    write_half(1'b1, sdld_pkg::HalfUpper, 8'h00);
    write_half(1'b1, sdld_pkg::HalfLower, 8'h00);
    write_half(1'b1, sdld_pkg::HalfLower, 8'h00);
    latch_col(4'hA);
    write_half(1'b0, sdld_pkg::HalfUpper, 8'h77);
    write_half(1'b0, sdld_pkg::HalfLower, 8'h08);
    write_half(1'b0, sdld_pkg::HalfUpper, 8'hF7);
    write_half(1'b0, sdld_pkg::HalfLower, 8'h88);
    write_half(1'b0, sdld_pkg::HalfLower, 8'h08);
    write_half(1'b0, sdld_pkg::HalfLower, 8'h08);
    issue_access(sdld_pkg::ReqColumnLatch, 4'h5, 1'b1, 1'b1, 8'hFF);
    write_half(1'b0, sdld_pkg::HalfUpper, 8'h3F);
    write_half(1'b0, sdld_pkg::HalfLower, 8'h00);
    latch_col(4'h0);
    write_half(1'b1, sdld_pkg::HalfLower, 8'h80);
    write_half(1'b1, sdld_pkg::HalfUpper, 8'h80);

    // Random: mostly whole glyphs at random places, the rest raw accesses
    accesses_sent = 0;
    while (accesses_sent < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        glyph   = seg_glyph_pkg::glyph_entry($urandom_range(0, seg_glyph_pkg::NumGlyphs - 1));
        pattern = glyph[15:0];
        if ($urandom_range(0, 7) == 0)
          pattern = pattern | ($urandom_range(0, 1) ? 16'h8000 : 16'h0080);
        sec = 1'($urandom);
        latch_col(4'($urandom));
        if ($urandom_range(0, 1) == 0) begin
          write_half(sec, sdld_pkg::HalfUpper, pattern[15:8]);
          write_half(sec, sdld_pkg::HalfLower, pattern[7:0]);
        end else begin
          write_half(sec, sdld_pkg::HalfLower, pattern[7:0]);
          write_half(sec, sdld_pkg::HalfUpper, pattern[15:8]);
        end
        // Rewrite one half, often leaving the word unchanged
        if ($urandom_range(0, 3) == 0)
          write_half(sec, sdld_pkg::HalfLower, pattern[7:0]);
      end else begin
        issue_access(1'($urandom), 4'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
      end
    end
    in_valid_i <= 1'b0;

    // Drain, then allow for the pipeline latency
    while (pending_updates != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (fail_count == 0 && pending_updates == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/sdld_pkg.sv
sv/segment_display_latch_decoder_top.sv
dv/display_char_checker.sv
dv/tb.sv
